[design/blpg_pkg.sv]
// Shared types and constants for the line point generator.
package blpg_pkg;

  // Item kind carried in the input tuser bit.
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Width of the point repeat register.
  localparam int REPEAT_W = 8;

  // Reset value of the point repeat register.
  localparam logic [REPEAT_W-1:0] REPEAT_RESET = 8'd1;

endpackage

[design/blpg_front.sv]
// Front end: classify each item and precompute endpoint differences and ordering.
module blpg_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                       kind,
  input  logic [COORD_WIDTH-1:0]     start_x,
  input  logic [COORD_WIDTH-1:0]     start_y,
  input  logic [COORD_WIDTH-1:0]     end_x,
  input  logic [COORD_WIDTH-1:0]     end_y,
  output logic [6*COORD_WIDTH+4:0]   entry
);

  logic                   x_gt;
  logic                   x_lt;
  logic                   y_gt;
  logic                   y_lt;
  logic [COORD_WIDTH-1:0] dx;
  logic [COORD_WIDTH-1:0] dy;

  always_comb begin
    x_gt = start_x > end_x;
    x_lt = start_x < end_x;
    y_gt = start_y > end_y;
    y_lt = start_y < end_y;
    dx   = x_gt ? (start_x - end_x) : (end_x - start_x);
    dy   = y_gt ? (start_y - end_y) : (end_y - start_y);
  end

  // Layout from the top: kind, x_gt, x_lt, y_gt, y_lt, dy, dx, by, bx, ay, ax.
  assign entry = {kind, x_gt, x_lt, y_gt, y_lt, dy, dx, end_y, end_x, start_y, start_x};

endmodule

[design/blpg_queue.sv]
// Short first-in first-out queue between front and back.
module blpg_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (blpg_pkg::QUEUE_DEPTH > 1) ? $clog2(blpg_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(blpg_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(blpg_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(blpg_pkg::QUEUE_DEPTH - 1);

  logic [WIDTH-1:0] mem_r [blpg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign wr_ready = count_r != FULL_CNT;
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[design/blpg_back.sv]
// Back end: line walk state, error update and registered point output.
module blpg_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [blpg_pkg::REPEAT_W-1:0]    point_repeat,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  logic [6*COORD_WIDTH+4:0]         q_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [COORD_WIDTH-1:0]           out_x,
  output logic [COORD_WIDTH-1:0]           out_y,
  output logic                             out_last
);

  localparam int CW = COORD_WIDTH;
  localparam int EW = COORD_WIDTH + 2;

  logic                   kind;
  logic                   x_gt;
  logic                   x_lt;
  logic                   y_gt;
  logic                   y_lt;
  logic [CW-1:0]          dy;
  logic [CW-1:0]          dx;
  logic [CW-1:0]          by;
  logic [CW-1:0]          bx;
  logic [CW-1:0]          ay;
  logic [CW-1:0]          ax;

  logic                   active_r;
  logic                   steep_r;
  logic [CW-1:0]          major_pos_r;
  logic [CW-1:0]          major_end_r;
  logic [CW-1:0]          minor_pos_r;
  logic [CW-1:0]          major_delta_r;
  logic [CW-1:0]          minor_delta_r;
  logic signed [EW-1:0]   error_r;
  logic                   minor_dir_r;
  logic [blpg_pkg::REPEAT_W-1:0] copy_count_r;

  logic                   out_valid_r;
  logic [CW-1:0]          out_x_r;
  logic [CW-1:0]          out_y_r;
  logic                   out_last_r;

  logic                   space;
  logic                   pop;
  logic                   emit;
  logic                   load;

  // Load setup.
  logic                   ld_steep;
  logic                   ld_swap;
  logic [CW-1:0]          ld_major;
  logic [CW-1:0]          ld_end;
  logic [CW-1:0]          ld_minor;
  logic [CW-1:0]          ld_mdelta;
  logic [CW-1:0]          ld_ndelta;
  logic                   ld_dir;

  // Tick step.
  logic                   first_copy;
  logic signed [EW-1:0]   err_sub;
  logic signed [EW-1:0]   err_step;
  logic [CW-1:0]          minor_step;
  logic [CW-1:0]          minor_cur;
  logic                   final_copy;
  logic [CW:0]            major_inc;
  logic                   last_pos;

  assign {kind, x_gt, x_lt, y_gt, y_lt, dy, dx, by, bx, ay, ax} = q_data;

  assign space   = !out_valid_r || out_ready;
  assign q_ready = (kind == blpg_pkg::KIND_LOAD) || space;
  assign pop     = q_valid && q_ready;
  assign load    = pop && (kind == blpg_pkg::KIND_LOAD);
  assign emit    = pop && (kind == blpg_pkg::KIND_TICK) && active_r;

  always_comb begin
    ld_steep  = dy > dx;
    ld_swap   = ld_steep ? y_gt : x_gt;
    if (ld_steep) begin
      ld_major = ld_swap ? by : ay;
      ld_end   = ld_swap ? ay : by;
      ld_minor = ld_swap ? bx : ax;
      ld_dir   = ld_swap ? !x_gt : !x_lt;
    end else begin
      ld_major = ld_swap ? bx : ax;
      ld_end   = ld_swap ? ax : bx;
      ld_minor = ld_swap ? by : ay;
      ld_dir   = ld_swap ? !y_gt : !y_lt;
    end
    ld_mdelta = ld_steep ? dy : dx;
    ld_ndelta = ld_steep ? dx : dy;
  end

  always_comb begin
    first_copy = copy_count_r == '0;
    err_sub    = error_r - $signed({2'b00, minor_delta_r});
    minor_step = minor_dir_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
    if (err_sub[EW-1]) begin
      err_step  = err_sub + $signed({2'b00, major_delta_r});
      minor_cur = first_copy ? minor_step : minor_pos_r;
    end else begin
      err_step  = err_sub;
      minor_cur = minor_pos_r;
    end
    final_copy = copy_count_r >= point_repeat;
    major_inc  = {1'b0, major_pos_r} + 1'b1;
    last_pos   = major_inc == {1'b0, major_end_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      steep_r       <= 1'b0;
      major_pos_r   <= '0;
      major_end_r   <= '0;
      minor_pos_r   <= '0;
      major_delta_r <= '0;
      minor_delta_r <= '0;
      error_r       <= '0;
      minor_dir_r   <= 1'b0;
      copy_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (load) begin
        active_r      <= ld_mdelta != '0;
        steep_r       <= ld_steep;
        major_pos_r   <= ld_major;
        major_end_r   <= ld_end;
        minor_pos_r   <= ld_minor;
        major_delta_r <= ld_mdelta;
        minor_delta_r <= ld_ndelta;
        error_r       <= $signed({2'b00, ld_mdelta >> 1});
        minor_dir_r   <= ld_dir;
        copy_count_r  <= '0;
      end else if (emit) begin
        if (first_copy) begin
          error_r     <= err_step;
          minor_pos_r <= minor_cur;
        end
        if (final_copy) begin
          copy_count_r <= '0;
          major_pos_r  <= major_inc[CW-1:0];
          active_r     <= !last_pos;
        end else begin
          copy_count_r <= copy_count_r + 1'b1;
        end
      end
      if (space) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r    <= steep_r ? minor_cur : major_pos_r;
      out_y_r    <= steep_r ? major_pos_r : minor_cur;
      out_last_r <= final_copy && last_pos;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;

endmodule

[design/bresenham_line_point_generator.sv]
// Top level of the Bresenham line point generator.
//
//   Channel  Dir  Signals                                  Content
//   in_      in   in_tvalid/in_tready/in_tdata/in_tuser    line command or output tick
//   out_     out  out_tvalid/out_tready/out_tdata/out_tlast one copy of one line point
//   cfg_     in   cfg_valid/cfg_ready/cfg_data             point_repeat register
//
// One input item per cycle is taken while the queue has room; a tick on an
// active line yields one point copy, so the sustained rate is one copy per
// cycle while out_ is not stalled.
// A tick is registered in the queue; its point is then registered in the output register.
// Synchronous active-low reset empties the queue, idles the walk and sets point_repeat to 1.
// An output stall holds ticks in the queue; a load at its head still drains during a stall.
module bresenham_line_point_generator #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata, from the lowest bit: start_x, start_y, end_x, end_y, zero fill
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]  in_tdata,
  // in_tuser: kind (0 load line, 1 tick)
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata, from the lowest bit: point_x, point_y, zero fill
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]  out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [blpg_pkg::REPEAT_W-1:0]       cfg_data
);

  localparam int CW      = COORD_WIDTH;
  localparam int ENTRY_W = 6 * COORD_WIDTH + 5;
  localparam int OUT_W   = ((2 * COORD_WIDTH + 7) / 8) * 8;

  logic [blpg_pkg::REPEAT_W-1:0] point_repeat_r;
  logic [ENTRY_W-1:0]            front_entry;
  logic                          q_valid;
  logic                          q_ready;
  logic [ENTRY_W-1:0]            q_data;
  logic [CW-1:0]                 point_x;
  logic [CW-1:0]                 point_y;

  // Always take register writes; the new repeat applies to every tick walked afterward,
  // so write it only while nothing is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_repeat_r <= blpg_pkg::REPEAT_RESET;
    end else if (cfg_valid) begin
      point_repeat_r <= cfg_data;
    end
  end

  // Classify the item and precompute differences and endpoint order.
  blpg_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .kind    (in_tuser),
    .start_x (in_tdata[CW-1:0]),
    .start_y (in_tdata[2*CW-1:CW]),
    .end_x   (in_tdata[3*CW-1:2*CW]),
    .end_y   (in_tdata[4*CW-1:3*CW]),
    .entry   (front_entry)
  );

  // Decouple acceptance from the walk so each side can stall on its own.
  blpg_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (front_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Walk the line and register each point copy.
  blpg_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_repeat (point_repeat_r),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_x        (point_x),
    .out_y        (point_y),
    .out_last     (out_tlast)
  );

  // Pack the point, zero filling up to whole bytes.
  assign out_tdata = OUT_W'({point_y, point_x});

endmodule
